/* rtl/rqs_pkg.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler package
// Shared widths, codes, payload types and the controller/datapath interface
// types of the ready queue scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int ID_W       = 5;
    localparam int LEN_W      = 16;
    localparam int QCNT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] QUANTUM_RESET = 16'd500;

    // Item kinds.
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_RR   = 2'd1,
        POL_SJF  = 2'd2,
        POL_PSJF = 2'd3
    } t_policy;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   task_id;
        logic [LEN_W-1:0]  burst;
    } t_in_item;

    typedef struct packed {
        logic              run_valid;
        logic [ID_W-1:0]   run_id;
        logic              done_valid;
        logic [ID_W-1:0]   done_id;
        logic              rejected;
        logic [QCNT_W-1:0] queue_count;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_beat;

    // One queue entry.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] rem;
    } t_slot;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ARR_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_TICK_ROT,
        ST_TICK_RD,
        ST_TICK_RUN,
        ST_RESP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_REJECT,
        DP_PUT_FIRST,
        DP_APPEND,
        DP_RD_HEAD,
        DP_PUSH_FRONT,
        DP_SCAN_START,
        DP_SCAN_RD,
        DP_SCAN_STEP,
        DP_SCAN_PUT,
        DP_IDLE_TICK,
        DP_ROTATE,
        DP_RUN,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic full;
        logic empty;
        logic ordered;
        logic rot_due;
        logic front_ok;
        logic scan_end;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/rqs_chan_if.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler channel
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface rqs_chan_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/rqs_ctrl.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler controller
// Sequences one item at a time through the datapath and hands over results.
// ----------------------------------------------------------------------------
module rqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rqs_pkg::t_dp_stat i_stat,
    output rqs_pkg::t_dp_cmd  o_cmd
);
    import rqs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_stat.is_tick) begin
                    if (i_stat.empty)        n_state = ST_RESP;
                    else if (i_stat.rot_due) n_state = ST_TICK_ROT;
                    else                     n_state = ST_TICK_RUN;
                end else begin
                    if (i_stat.full || i_stat.empty || !i_stat.ordered) n_state = ST_RESP;
                    else                                                n_state = ST_ARR_CMP;
                end
            end
            ST_ARR_CMP: begin
                n_state = i_stat.front_ok ? ST_RESP : ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = i_stat.scan_end ? ST_RESP : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: n_state = ST_SCAN_RD;
            ST_TICK_ROT: n_state = ST_TICK_RD;
            ST_TICK_RD:  n_state = ST_TICK_RUN;
            ST_TICK_RUN: n_state = ST_RESP;
            ST_RESP: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = DP_LOAD;
            end
            ST_DECODE: begin
                if (i_stat.is_tick) begin
                    o_cmd.op = i_stat.empty ? DP_IDLE_TICK : DP_RD_HEAD;
                end else if (i_stat.full) begin
                    o_cmd.op = DP_REJECT;
                end else if (i_stat.empty) begin
                    o_cmd.op = DP_PUT_FIRST;
                end else if (!i_stat.ordered) begin
                    o_cmd.op = DP_APPEND;
                end else begin
                    o_cmd.op = DP_RD_HEAD;
                end
            end
            ST_ARR_CMP: begin
                o_cmd.op = i_stat.front_ok ? DP_PUSH_FRONT : DP_SCAN_START;
            end
            ST_SCAN_RD: begin
                o_cmd.op = i_stat.scan_end ? DP_SCAN_PUT : DP_SCAN_RD;
            end
            ST_SCAN_CMP: o_cmd.op = DP_SCAN_STEP;
            ST_TICK_ROT: o_cmd.op = DP_ROTATE;
            ST_TICK_RD:  o_cmd.op = DP_RD_HEAD;
            ST_TICK_RUN: o_cmd.op = DP_RUN;
            ST_RESP: begin
                if (i_stat.out_free) o_cmd.op = DP_RESULT;
            end
            default: o_cmd.op = DP_NOP;
        endcase
    end

endmodule

/* rtl/rqs_datapath.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler datapath
// Circular queue memory, scheduler state, configuration and result register.
// ----------------------------------------------------------------------------
module rqs_datapath #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rqs_pkg::t_dp_cmd  i_cmd,
    output rqs_pkg::t_dp_stat o_stat,
    input  rqs_pkg::t_in_item i_item_data,
    rqs_chan_if.source        o_result,
    rqs_chan_if.sink          i_cfg
);
    import rqs_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = CW + 1;

    // Queue storage, addressed physically; logical position 0 sits at r_head.
    t_slot r_mem [MAX_ENTRIES];
    t_slot r_rd_slot;

    t_policy          r_policy;
    logic [LEN_W-1:0] r_quantum;
    logic [IW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic             r_running;
    logic [LEN_W-1:0] r_slice;
    logic [CW-1:0]    r_pos;
    logic             r_shifting;
    logic             r_kind;
    t_slot            r_carry;
    logic             r_run_valid;
    logic [ID_W-1:0]  r_run_id;
    logic             r_done_valid;
    logic             r_rejected;
    logic             r_out_valid;
    t_result          r_out;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    t_slot            mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;
    logic [IW-1:0]    head_inc;
    logic [IW-1:0]    head_dec;
    logic [LEN_W-1:0] rem_dec;
    logic [LEN_W-1:0] slice_inc;
    logic [LEN_W-1:0] quantum_eff;
    logic             shift_now;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(lidx);
        if (sum >= SW'(MAX_ENTRIES)) sum = sum - SW'(MAX_ENTRIES);
        return sum[IW-1:0];
    endfunction

    assign head_inc    = (r_head == IW'(MAX_ENTRIES - 1)) ? '0 : r_head + IW'(1);
    assign head_dec    = (r_head == '0) ? IW'(MAX_ENTRIES - 1) : r_head - IW'(1);
    assign rem_dec     = (r_rd_slot.rem == '0) ? '0 : r_rd_slot.rem - LEN_W'(1);
    assign slice_inc   = (r_slice == '1) ? r_slice : r_slice + LEN_W'(1);
    assign quantum_eff = (r_quantum == '0) ? LEN_W'(1) : r_quantum;
    assign shift_now   = r_shifting || (r_carry.rem < r_rd_slot.rem);

    always_comb begin
        o_stat.is_tick  = (r_kind == KIND_TICK);
        o_stat.full     = (r_count >= CW'(MAX_ENTRIES));
        o_stat.empty    = (r_count == '0);
        o_stat.ordered  = (r_policy == POL_SJF) || (r_policy == POL_PSJF);
        o_stat.rot_due  = (r_policy == POL_RR) && (r_slice >= quantum_eff);
        o_stat.front_ok = (r_carry.rem < r_rd_slot.rem) &&
                          ((r_policy == POL_PSJF) || !r_running);
        o_stat.scan_end = (r_pos == r_count);
        o_stat.out_free = !r_out_valid || o_result.ready;
    end

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = r_carry;
        mem_re    = 1'b0;
        mem_raddr = r_head;
        case (i_cmd.op)
            DP_PUT_FIRST: begin
                mem_we = 1'b1;
            end
            DP_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_count);
            end
            DP_PUSH_FRONT: begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
            end
            DP_RD_HEAD: begin
                mem_re = 1'b1;
            end
            DP_SCAN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = phys(r_head, r_pos);
            end
            DP_SCAN_STEP: begin
                mem_we    = shift_now;
                mem_waddr = phys(r_head, r_pos);
            end
            DP_SCAN_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_pos);
            end
            DP_ROTATE: begin
                mem_we    = (r_count > CW'(1));
                mem_waddr = phys(r_head, r_count);
                mem_wdata = r_rd_slot;
            end
            DP_RUN: begin
                mem_we    = (rem_dec != '0);
                mem_wdata = '{id: r_rd_slot.id, rem: rem_dec};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_slot <= r_mem[mem_raddr];
    end

    // Control state: configuration, queue pointers and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FIFO;
            r_quantum   <= QUANTUM_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_slice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.payload.index)
                    CFG_POLICY:  r_policy  <= t_policy'(i_cfg.payload.value[1:0]);
                    CFG_QUANTUM: r_quantum <= i_cfg.payload.value;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                DP_PUT_FIRST: begin
                    r_count <= r_count + CW'(1);
                    r_slice <= '0;
                end
                DP_APPEND, DP_SCAN_PUT: begin
                    r_count <= r_count + CW'(1);
                end
                DP_PUSH_FRONT: begin
                    r_head  <= head_dec;
                    r_count <= r_count + CW'(1);
                    r_slice <= '0;
                end
                DP_SCAN_STEP: begin
                    if (shift_now && r_pos == r_count - CW'(1)) begin
                        // The displaced tail entry still has to be written.
                        r_count <= r_count;
                    end
                end
                DP_IDLE_TICK: begin
                    r_running <= 1'b0;
                end
                DP_ROTATE: begin
                    if (r_count > CW'(1)) r_head <= head_inc;
                    r_slice <= '0;
                end
                DP_RUN: begin
                    if (rem_dec == '0) begin
                        r_head    <= head_inc;
                        r_count   <= r_count - CW'(1);
                        r_slice   <= '0;
                        r_running <= 1'b0;
                    end else begin
                        r_slice   <= slice_inc;
                        r_running <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_cmd.op == DP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_kind       <= i_item_data.kind;
                r_carry.id   <= i_item_data.task_id;
                r_carry.rem  <= (i_item_data.burst == '0) ? LEN_W'(1) : i_item_data.burst;
                r_run_valid  <= 1'b0;
                r_run_id     <= '0;
                r_done_valid <= 1'b0;
                r_rejected   <= 1'b0;
                r_shifting   <= 1'b0;
            end
            DP_REJECT: begin
                r_rejected <= 1'b1;
            end
            DP_SCAN_START: begin
                r_pos <= CW'(1);
            end
            DP_SCAN_STEP: begin
                if (shift_now) begin
                    r_carry    <= r_rd_slot;
                    r_shifting <= 1'b1;
                end
                r_pos <= r_pos + CW'(1);
            end
            DP_RUN: begin
                r_run_valid  <= 1'b1;
                r_run_id     <= r_rd_slot.id;
                r_done_valid <= (rem_dec == '0);
            end
            DP_RESULT: begin
                r_out.run_valid   <= r_run_valid;
                r_out.run_id      <= r_run_id;
                r_out.done_valid  <= r_done_valid;
                r_out.done_id     <= r_done_valid ? r_run_id : '0;
                r_out.rejected    <= r_rejected;
                r_out.queue_count <= QCNT_W'(r_count);
            end
            default: ;
        endcase
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;
    assign i_cfg.ready      = 1'b1;

endmodule

/* rtl/ready_queue_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler
// Task ready queue with FIFO, round robin and shortest-job-first policies.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Beat contents
//   i_item     in         kind, task_id, burst
//   o_result   out        run_valid, run_id, done_valid, done_id, rejected,
//                         queue_count
//   i_cfg      in         index (0 policy, 1 quantum), value
//
// One item is handled at a time; the controller steps the datapath through
// a single-port queue memory with registered read data. An arrival in FIFO
// or round robin order, an arrival into an empty or full queue and a tick
// on an empty queue go from decode straight to the result. A tick reads the
// head and then runs it; when round robin rotates, it first moves the head
// to the tail and reads the new head. An ordered arrival reads the head and
// either goes in front of it or scans, reading and comparing each entry
// behind the head in turn, and then puts the new entry in its place.
// Synchronous reset empties the queue and restores the register defaults;
// the queue memory itself is not cleared, as only held entries are read.
// A stalled result waits in the output register while the next item is
// accepted and processed; that item then holds in its final state until the
// output register has been freed.
// Configuration writes are always accepted and take effect at once.
//
// Entries sit in a circular buffer. Popping the head and pushing in front of
// it only move the head pointer; an ordered insert scans forward from the
// second entry and, once it finds the first longer job, ripples the entries
// behind it one place towards the tail.
// ----------------------------------------------------------------------------
module ready_queue_scheduler_top #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rqs_chan_if.sink    i_item,
    rqs_chan_if.source  o_result,
    rqs_chan_if.sink    i_cfg
);
    import rqs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // The controller decides which datapath operation runs in each cycle.
    rqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath owns the queue, the configuration and the result beat.
    rqs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item_data (i_item.payload),
        .o_result    (o_result),
        .i_cfg       (i_cfg)
    );

    assign i_item.ready = in_ready;

    // An accepted item keeps the input closed in the following cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted while an item is in progress");

    // A finished task is always the task that ran in the same tick.
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.done_valid) |->
        (o_result.payload.run_valid &&
         o_result.payload.done_id == o_result.payload.run_id))
        else $error("finished task differs from the task that ran");

    // A rejected arrival never reports a task running.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.rejected) |->
        (!o_result.payload.run_valid && !o_result.payload.done_valid))
        else $error("rejected arrival carries run information");

    // A waiting result beat holds still until the sink takes it.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=>
        (o_result.valid && $stable(o_result.payload)))
        else $error("result beat changed or vanished while stalled");

endmodule

/* tb/sv/ready_queue_scheduler_top_tb.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler testbench
// Drives arrivals and ticks under all four policies with random gaps on the
// item and result channels. It predicts every result beat in a scoreboard and
// checks the beats field by field.
// ----------------------------------------------------------------------------
module ready_queue_scheduler_top_tb;

    import rqs_pkg::*;

    localparam int QUEUE_DEPTH    = 32;
    localparam int RANDOM_ITEMS   = 650;
    localparam int WATCHDOG_LIMIT = 4000;

    // Register indexes that the block does not implement; writes to them must
    // leave both registers untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the ready queue and the two
    // registers. Each accepted item beat is run through that copy at once, so
    // the queue of expected results always lines up with the block's output
    // order: the block handles one item at a time.
    // ------------------------------------------------------------------------
    class ready_queue_scoreboard;

        t_policy           policy;
        logic [LEN_W-1:0]  quantum;
        logic [ID_W-1:0]   slot_ids   [QUEUE_DEPTH];
        logic [LEN_W-1:0]  slot_rems  [QUEUE_DEPTH];
        int                held;
        bit                busy;
        logic [LEN_W-1:0]  slice;
        t_result           expected_outcomes [$];

        int mismatches;
        int checked;
        int completions;
        int turned_away;
        int rotations;
        int reg_writes;

        function new();
            policy      = POL_FIFO;
            quantum     = QUANTUM_RESET;
            held        = 0;
            busy        = 1'b0;
            slice       = '0;
            mismatches  = 0;
            checked     = 0;
            completions = 0;
            turned_away = 0;
            rotations   = 0;
            reg_writes  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            case (index)
                CFG_POLICY: begin
                    policy = t_policy'(value[1:0]);
                end
                CFG_QUANTUM: begin
                    quantum = value[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Opens a gap at pos and drops the task into it.
        function void place_task(int pos, logic [ID_W-1:0] id, logic [LEN_W-1:0] rem);
            int i;
            for (i = held; i > pos; i--) begin
                slot_ids[i]  = slot_ids[i-1];
                slot_rems[i] = slot_rems[i-1];
            end
            slot_ids[pos]  = id;
            slot_rems[pos] = rem;
            held++;
            if (pos == 0)
                slice = '0;
        endfunction

        function void pop_head();
            int i;
            for (i = 1; i < held; i++) begin
                slot_ids[i-1]  = slot_ids[i];
                slot_rems[i-1] = slot_rems[i];
            end
            held--;
            slice = '0;
        endfunction

        function void insert_arrival(logic [ID_W-1:0] id, logic [LEN_W-1:0] rem);
            int pos;
            if (held == 0) begin
                place_task(0, id, rem);
            end else if (policy == POL_FIFO || policy == POL_RR) begin
                place_task(held, id, rem);
            end else if (rem < slot_rems[0] && (policy == POL_PSJF || !busy)) begin
                place_task(0, id, rem);
            end else begin
                // Shortest-job order, ties behind the entries already there.
                pos = 1;
                while (pos < held && rem >= slot_rems[pos])
                    pos++;
                place_task(pos, id, rem);
            end
        endfunction

        function void note_item(t_in_item beat_in);
            t_result           outcome;
            logic [LEN_W-1:0]  rem;
            logic [LEN_W-1:0]  slice_len;
            logic [ID_W-1:0]   head_id;
            logic [LEN_W-1:0]  head_rem;
            outcome = '0;
            if (beat_in.kind == KIND_ARRIVE) begin
                rem = (beat_in.burst == '0) ? LEN_W'(1) : beat_in.burst;
                if (held >= QUEUE_DEPTH) begin
                    outcome.rejected = 1'b1;
                    turned_away++;
                end else begin
                    insert_arrival(beat_in.task_id, rem);
                end
            end else if (held == 0) begin
                busy = 1'b0;
            end else begin
                slice_len = (quantum == '0) ? LEN_W'(1) : quantum;
                if (policy == POL_RR && slice >= slice_len) begin
                    if (held > 1) begin
                        head_id  = slot_ids[0];
                        head_rem = slot_rems[0];
                        pop_head();
                        slot_ids[held]  = head_id;
                        slot_rems[held] = head_rem;
                        held++;
                        rotations++;
                    end
                    slice = '0;
                end
                outcome.run_valid = 1'b1;
                outcome.run_id    = slot_ids[0];
                if (slice != '1)
                    slice++;
                if (slot_rems[0] != '0)
                    slot_rems[0]--;
                if (slot_rems[0] == '0) begin
                    outcome.done_valid = 1'b1;
                    outcome.done_id    = slot_ids[0];
                    pop_head();
                    busy = 1'b0;
                    completions++;
                end else begin
                    busy = 1'b1;
                end
            end
            outcome.queue_count = QCNT_W'(held);
            expected_outcomes.push_back(outcome);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, got %p", $time, got);
                return;
            end
            want = expected_outcomes.pop_front();
            checked++;
            compare_field("run_valid",   want.run_valid,   got.run_valid);
            compare_field("run_id",      want.run_id,      got.run_id);
            compare_field("done_valid",  want.done_valid,  got.done_valid);
            compare_field("done_id",     want.done_id,     got.done_id);
            compare_field("rejected",    want.rejected,    got.rejected);
            compare_field("queue_count", want.queue_count, got.queue_count);
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block itself.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    rqs_chan_if #(.t_payload(t_in_item))  item_ch ();
    rqs_chan_if #(.t_payload(t_result))   result_ch ();
    rqs_chan_if #(.t_payload(t_cfg_beat)) cfg_ch ();

    ready_queue_scheduler_top #(
        .MAX_ENTRIES(QUEUE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    ready_queue_scoreboard sb;

    // While calm is set, neither side inserts any idle cycles.
    bit calm;
    int items_sent;
    int phases_run;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 2);
        if (roll < 96)
            return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // Short bursts keep tasks finishing and the queue turning over; a few long
    // ones reach the upper bits of the field and sit at the tail for good.
    function automatic logic [LEN_W-1:0] pick_burst();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return LEN_W'($urandom_range(0, 5));
        if (roll < 92)
            return LEN_W'($urandom_range(6, 40));
        if (roll < 98)
            return LEN_W'($urandom_range(41, 600));
        return LEN_W'($urandom_range(1024, 65535));
    endfunction

    function automatic t_in_item make_item(logic kind, int id, int burst);
        t_in_item beat_out;
        beat_out.kind    = kind;
        beat_out.task_id = ID_W'(id);
        beat_out.burst   = LEN_W'(burst);
        return beat_out;
    endfunction

    function automatic t_in_item random_item(int arrive_pct);
        t_in_item beat_out;
        beat_out.kind    = ($urandom_range(0, 99) < arrive_pct) ? KIND_ARRIVE : KIND_TICK;
        beat_out.task_id = ID_W'($urandom_range(0, 31));
        // A tick ignores the other fields, so they are left random there too.
        beat_out.burst   = (beat_out.kind == KIND_ARRIVE) ? pick_burst() : LEN_W'($urandom());
        return beat_out;
    endfunction

    // Offers one item beat and holds it until the block takes it. The valid is
    // only dropped when a gap follows or the phase ends, so back-to-back beats
    // never see valid lowered and raised within the same time step.
    task automatic drive_item(input t_in_item beat_in, input bit last_of_phase);
        int gap;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= beat_in;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        gap = pick_gap();
        if (gap != 0 || last_of_phase)
            item_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        t_cfg_beat beat_out;
        beat_out.index = index;
        beat_out.value = value;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= beat_out;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers are only touched once every result has come back. Each item
    // yields exactly one result, so the block is idle by then; a short pause
    // covers the step back to its idle state. The first edge lets the monitor
    // note an item that was accepted at the edge just passed.
    task automatic wait_idle();
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready drops for random stretches, mostly short and now
    // and then long, with a spread of lengths of its own.
    // ------------------------------------------------------------------------
    initial begin : result_stalls
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (calm || $urandom_range(0, 99) >= 30) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 99) < 90 ? $urandom_range(0, 4)
                                                        : $urandom_range(10, 40);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Every accepted beat is seen here. A result always belongs to an older
    // item than one taken at the same edge, so it is checked first.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.payload);
            if (item_ch.valid && item_ch.ready)
                sb.note_item(item_ch.payload);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.payload.index, cfg_ch.payload.value);
        end
    end

    // The watchdog ends a run in which no beat moves on any channel for too
    // long, which also catches results that never arrive.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                      random_items;
        int                      arrive_pct;
        int                      phase_len;
        int                      k;
        int                      quantum_roll;
        t_policy                 pol;
        logic [CFG_DATA_W-1:0]   wdata;

        sb          = new();
        calm        = 1'b0;
        items_sent  = 0;
        phases_run  = 0;
        idle_cycles = 0;

        i_rst_n         <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.payload  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset registers (FIFO, slice of 500): a tick
        // on an empty queue, a zero burst that counts as one, the extreme ids,
        // and ticks until the queue is empty again.
        drive_item(make_item(KIND_TICK,   0, 0),     1'b0);
        drive_item(make_item(KIND_ARRIVE, 0, 0),     1'b0);
        drive_item(make_item(KIND_ARRIVE, 31, 1),    1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),     1'b0);
        drive_item(make_item(KIND_TICK,   31, 65535), 1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),     1'b1);

        // Round robin with a zero quantum, which behaves as a slice of one, so
        // a head that has run is rotated before it runs again. The policy value
        // carries junk in its upper bits; unused index writes must change nothing.
        wait_idle();
        write_reg(CFG_POLICY, 16'hFFFD);
        write_reg(CFG_QUANTUM, 16'h0000);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        drive_item(make_item(KIND_ARRIVE, 5, 3),   1'b0);
        drive_item(make_item(KIND_ARRIVE, 10, 2),  1'b0);
        drive_item(make_item(KIND_ARRIVE, 21, 1),  1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),   1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),   1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),   1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),   1'b1);

        // Non-preemptive shortest job first with the widest slice: a shorter
        // job may not overtake a running head, and the longest burst goes to
        // the tail.
        wait_idle();
        write_reg(CFG_POLICY, {14'h0, POL_SJF});
        write_reg(CFG_QUANTUM, 16'hFFFF);
        drive_item(make_item(KIND_ARRIVE, 1, 4),     1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),     1'b0);
        drive_item(make_item(KIND_ARRIVE, 2, 1),     1'b0);
        drive_item(make_item(KIND_ARRIVE, 3, 65535), 1'b0);
        drive_item(make_item(KIND_ARRIVE, 4, 4),     1'b0);
        drive_item(make_item(KIND_TICK,   0, 0),     1'b1);

        // Preemptive shortest job first: a shorter arrival takes the head.
        wait_idle();
        write_reg(CFG_POLICY, {14'h0, POL_PSJF});
        write_reg(CFG_QUANTUM, 16'd1);
        drive_item(make_item(KIND_ARRIVE, 6, 1), 1'b0);
        drive_item(make_item(KIND_TICK,   0, 0), 1'b0);
        drive_item(make_item(KIND_TICK,   0, 0), 1'b1);

        // Random phases. Each phase sets both registers, picks a mix of
        // arrivals and ticks and may turn idling off altogether. Fill-heavy
        // phases push the queue to full so that arrivals are turned away;
        // tick-heavy ones drain it again.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            pol   = (phases_run < 4) ? t_policy'(phases_run) : t_policy'($urandom_range(0, 3));
            wdata = CFG_DATA_W'($urandom());
            wdata[1:0] = pol;
            write_reg(CFG_POLICY, wdata);

            quantum_roll = $urandom_range(0, 99);
            if (quantum_roll < 50)
                wdata = CFG_DATA_W'($urandom_range(1, 6));
            else if (quantum_roll < 65)
                wdata = CFG_DATA_W'($urandom_range(7, 40));
            else if (quantum_roll < 75)
                wdata = '0;
            else if (quantum_roll < 85)
                wdata = '1;
            else
                wdata = CFG_DATA_W'($urandom());
            write_reg(CFG_QUANTUM, wdata);

            if ($urandom_range(0, 4) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          CFG_DATA_W'($urandom()));

            calm <= ($urandom_range(0, 3) == 0);
            if (phases_run == 0 || $urandom_range(0, 4) == 0)
                arrive_pct = 85;
            else
                arrive_pct = ($urandom_range(0, 1) != 0) ? 25 : 35;

            phase_len = $urandom_range(30, 70);
            for (k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++) begin
                drive_item(random_item(arrive_pct),
                           (k == phase_len - 1) || (random_items == RANDOM_ITEMS - 1));
                random_items++;
            end
            phases_run++;
        end

        // Drain: every expectation must be met (the watchdog catches the
        // rest), then a spell as long as the slowest ordered insert so that a
        // stray extra result beat would still be seen. The first edge lets the
        // monitor note the last accepted item.
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (2 * QUEUE_DEPTH + 8) @(posedge i_clk);

        $display("Run covered %0d items over %0d random phases and %0d register writes.",
                 items_sent, phases_run, sb.reg_writes);
        $display("Checked %0d results: %0d done, %0d refused, %0d rotations, %0d mismatches.",
                 sb.checked, sb.completions, sb.turned_away, sb.rotations, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rqs_pkg.sv
rtl/rqs_chan_if.sv
rtl/rqs_ctrl.sv
rtl/rqs_datapath.sv
rtl/ready_queue_scheduler_top.sv
tb/sv/ready_queue_scheduler_top_tb.sv
